>>> src/vpmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpmc_pkg
// Shared types, widths, microcode program and helpers for the voxel point
// mean and covariance block.
// ----------------------------------------------------------------------------
package vpmc_pkg;

    // capacity and field widths
    localparam int MAX_POINTS = 31;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CRD_W      = 24;
    localparam int MEAN_W     = 24;
    localparam int COV_W      = 48;
    localparam int DIF_W      = CRD_W + 1;
    localparam int PRD_W      = 2 * DIF_W;
    localparam int MAG_W      = CNT_W + PRD_W;
    localparam int NCOV       = 6;
    localparam int NAXIS      = 3;
    localparam int K_W        = 3;

    // divider: one chunk of quotient bits per cycle
    localparam int DIV_CHUNK  = 8;
    localparam int DIV_STEPS  = (MAG_W + 1 + DIV_CHUNK - 1) / DIV_CHUNK;
    localparam int DIV_W      = DIV_STEPS * DIV_CHUNK;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
    localparam int D1_W       = $clog2(MAX_POINTS + 2);
    localparam int D2_W       = 2 * D1_W;
    localparam int SUM_W      = DIV_W + 2;

    // sequencer
    localparam int PC_W       = 5;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_CLEARED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIFF,
        OP_MULD,
        OP_SCALE,
        OP_DIVGO,
        OP_KEEPB,
        OP_COVSUM,
        OP_MEANSUM,
        OP_COMMIT,
        OP_CLEAR,
        OP_HOLD
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_HOLD,
        C_LAST,
        C_DIV_BUSY,
        C_COV_MORE,
        C_MEAN_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        SRC_PROD,
        SRC_COV,
        SRC_DIFF
    } src_t;

    typedef enum logic {
        DEN_SQ,
        DEN_LIN
    } den_t;

    typedef struct packed {
        op_t             op;
        src_t            src;
        logic            scale_n;
        den_t            den;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    // program addresses
    localparam logic [PC_W-1:0] A_CHK     = 5'd0;
    localparam logic [PC_W-1:0] A_LAST    = 5'd1;
    localparam logic [PC_W-1:0] A_DIFF    = 5'd2;
    localparam logic [PC_W-1:0] A_MULD    = 5'd3;
    localparam logic [PC_W-1:0] A_SCB     = 5'd4;
    localparam logic [PC_W-1:0] A_DVB     = 5'd5;
    localparam logic [PC_W-1:0] A_WTB     = 5'd6;
    localparam logic [PC_W-1:0] A_KEEPB   = 5'd7;
    localparam logic [PC_W-1:0] A_SCA     = 5'd8;
    localparam logic [PC_W-1:0] A_DVA     = 5'd9;
    localparam logic [PC_W-1:0] A_WTA     = 5'd10;
    localparam logic [PC_W-1:0] A_COVSUM  = 5'd11;
    localparam logic [PC_W-1:0] A_SCM     = 5'd12;
    localparam logic [PC_W-1:0] A_DVM     = 5'd13;
    localparam logic [PC_W-1:0] A_WTM     = 5'd14;
    localparam logic [PC_W-1:0] A_MEANSUM = 5'd15;
    localparam logic [PC_W-1:0] A_WOC     = 5'd16;
    localparam logic [PC_W-1:0] A_COMMIT  = 5'd17;
    localparam logic [PC_W-1:0] A_WCL     = 5'd18;
    localparam logic [PC_W-1:0] A_CLEAR   = 5'd19;
    localparam logic [PC_W-1:0] A_WHD     = 5'd20;
    localparam logic [PC_W-1:0] A_HOLD    = 5'd21;

    // control store: one word per step
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c.op      = OP_NOP;
        c.src     = SRC_PROD;
        c.scale_n = 1'b0;
        c.den     = DEN_LIN;
        c.cond    = C_NEVER;
        c.target  = A_CHK;
        case (pc)
            A_CHK:
            begin
                c.cond   = C_HOLD;
                c.target = A_WHD;
            end
            A_LAST:
            begin
                c.cond   = C_LAST;
                c.target = A_WCL;
            end
            A_DIFF:    c.op = OP_DIFF;
            A_MULD:    c.op = OP_MULD;
            A_SCB:
            begin
                c.op      = OP_SCALE;
                c.src     = SRC_PROD;
                c.scale_n = 1'b1;
            end
            A_DVB:
            begin
                c.op  = OP_DIVGO;
                c.den = DEN_SQ;
            end
            A_WTB:
            begin
                c.cond   = C_DIV_BUSY;
                c.target = A_WTB;
            end
            A_KEEPB:   c.op = OP_KEEPB;
            A_SCA:
            begin
                c.op      = OP_SCALE;
                c.src     = SRC_COV;
                c.scale_n = 1'b1;
            end
            A_DVA:
            begin
                c.op  = OP_DIVGO;
                c.den = DEN_LIN;
            end
            A_WTA:
            begin
                c.cond   = C_DIV_BUSY;
                c.target = A_WTA;
            end
            A_COVSUM:
            begin
                c.op     = OP_COVSUM;
                c.cond   = C_COV_MORE;
                c.target = A_MULD;
            end
            A_SCM:
            begin
                c.op      = OP_SCALE;
                c.src     = SRC_DIFF;
                c.scale_n = 1'b0;
            end
            A_DVM:
            begin
                c.op  = OP_DIVGO;
                c.den = DEN_LIN;
            end
            A_WTM:
            begin
                c.cond   = C_DIV_BUSY;
                c.target = A_WTM;
            end
            A_MEANSUM:
            begin
                c.op     = OP_MEANSUM;
                c.cond   = C_MEAN_MORE;
                c.target = A_SCM;
            end
            A_WOC:
            begin
                c.cond   = C_OUT_BUSY;
                c.target = A_WOC;
            end
            A_COMMIT:  c.op = OP_COMMIT;
            A_WCL:
            begin
                c.cond   = C_OUT_BUSY;
                c.target = A_WCL;
            end
            A_CLEAR:   c.op = OP_CLEAR;
            A_WHD:
            begin
                c.cond   = C_OUT_BUSY;
                c.target = A_WHD;
            end
            A_HOLD:    c.op = OP_HOLD;
            default:   c.op = OP_NOP;
        endcase
        return c;
    endfunction

    // clamp a wide sum to a covariance term
    function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COV_W:0] top;
        top = v[SUM_W-1:COV_W-1];
        if ((&top) || !(|top))
            return v[COV_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(COV_W-1){1'b0}}};
        else
            return {1'b0, {(COV_W-1){1'b1}}};
    endfunction

    // clamp a wide sum to a mean coordinate
    function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-MEAN_W:0] top;
        top = v[SUM_W-1:MEAN_W-1];
        if ((&top) || !(|top))
            return v[MEAN_W-1:0];
        else if (v[SUM_W-1])
            return {1'b1, {(MEAN_W-1){1'b0}}};
        else
            return {1'b0, {(MEAN_W-1){1'b1}}};
    endfunction

endpackage
`default_nettype wire

>>> src/voxel_point_mean_covariance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_point_mean_covariance
// Running count, mean and population covariance of the 3D points in one
// voxel, with insert and exact-inverse remove, driven by a microcoded
// sequencer over one multiplier pair and a chunked divider.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | request   | in_valid / in_stall | func, px, py, pz
//  out     | result    | out_valid/out_stall | point_count, mean_*, cov_*, status
//
//  An applied insert or remove runs 12 divisions for the covariance terms
//  and 3 for the mean, each one in the 8-bit-per-cycle divider with the
//  sequencer held in a wait step until it is done, plus set-up steps.
//  Ignored requests and a remove of the last point skip the divisions.
//  One request is worked on at a time; the next is taken while a result waits.
//  A result held by out_stall delays only the final commit, clear or hold step of the next request.
//  Reset clears the count, mean and covariance to zero.
// ----------------------------------------------------------------------------
module voxel_point_mean_covariance (
    input  wire  logic                clk,
    input  wire  logic                rst_n,
    input  wire  logic                in_valid,
    output logic                      in_stall,
    input  wire  logic                func,
    input  wire  logic signed [23:0]  px,
    input  wire  logic signed [23:0]  py,
    input  wire  logic signed [23:0]  pz,
    output logic                      out_valid,
    input  wire  logic                out_stall,
    output logic [4:0]                point_count,
    output logic signed [23:0]        mean_x,
    output logic signed [23:0]        mean_y,
    output logic signed [23:0]        mean_z,
    output logic signed [47:0]        cov_xx,
    output logic signed [47:0]        cov_xy,
    output logic signed [47:0]        cov_xz,
    output logic signed [47:0]        cov_yy,
    output logic signed [47:0]        cov_yz,
    output logic signed [47:0]        cov_zz,
    output logic [1:0]                status
);

    // sequencer and handshake state
    logic                               busy_reg, busy_next;
    logic [vpmc_pkg::PC_W-1:0]          pc_reg, pc_next;
    logic [vpmc_pkg::K_W-1:0]           k_reg, k_next;
    logic [vpmc_pkg::DCNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic                               out_valid_reg, out_valid_next;

    // held statistics
    logic [vpmc_pkg::CNT_W-1:0]         count_reg;
    logic signed [vpmc_pkg::MEAN_W-1:0] mean_reg [vpmc_pkg::NAXIS];
    logic signed [vpmc_pkg::COV_W-1:0]  cov_reg [vpmc_pkg::NCOV];
    logic [1:0]                         status_reg;

    // datapath registers
    logic                               func_reg;
    logic signed [vpmc_pkg::CRD_W-1:0]  p_reg [vpmc_pkg::NAXIS];
    logic signed [vpmc_pkg::DIF_W-1:0]  d_reg [vpmc_pkg::NAXIS];
    logic [vpmc_pkg::D1_W-1:0]          den1_reg;
    logic [vpmc_pkg::D2_W-1:0]          den2_reg;
    logic signed [vpmc_pkg::PRD_W-1:0]  prod_reg;
    logic [vpmc_pkg::MAG_W-1:0]         mag_reg;
    logic                               sgn_reg;
    logic [vpmc_pkg::DIV_W-1:0]         div_num_reg;
    logic [vpmc_pkg::D2_W-1:0]          div_rem_reg;
    logic [vpmc_pkg::D2_W-1:0]          div_den_reg;
    logic                               div_sgn_reg;
    logic signed [vpmc_pkg::DIV_W:0]    b_reg;
    logic signed [vpmc_pkg::COV_W-1:0]  cov_new_reg [vpmc_pkg::NCOV];
    logic signed [vpmc_pkg::MEAN_W-1:0] mean_new_reg [vpmc_pkg::NAXIS];

    // combinational signals
    vpmc_pkg::ctrl_t                    ctrl;
    vpmc_pkg::op_t                      op_eff;
    logic                               accept;
    logic                               out_take;
    logic                               is_remove;
    logic                               hold_c;
    logic                               last_c;
    logic                               jump;
    logic [vpmc_pkg::D1_W-1:0]          den1_val;
    logic signed [vpmc_pkg::DIF_W-1:0]  mul_a, mul_b;
    logic signed [vpmc_pkg::PRD_W-1:0]  src_val;
    logic [vpmc_pkg::PRD_W-1:0]         src_abs;
    logic [vpmc_pkg::CNT_W-1:0]         scale_fac;
    logic [vpmc_pkg::MAG_W-1:0]         scale_prod;
    logic [vpmc_pkg::D2_W-1:0]          den_sel;
    logic [vpmc_pkg::D2_W-1:0]          dv_rem;
    logic [vpmc_pkg::DIV_W-1:0]         dv_num;
    logic [vpmc_pkg::D2_W:0]            dv_trial;
    logic signed [vpmc_pkg::DIV_W:0]    quot_s;
    logic signed [vpmc_pkg::SUM_W-1:0]  cov_sum;
    logic signed [vpmc_pkg::SUM_W-1:0]  mean_sum;
    logic [vpmc_pkg::CNT_W+4:0]         count_ext;

    // handshake
    assign accept    = in_valid && !busy_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = busy_reg;
    assign is_remove = (func_reg == vpmc_pkg::FUNC_REMOVE);

    // control word fetch
    assign ctrl   = vpmc_pkg::ucode(pc_reg);
    assign op_eff = busy_reg ? ctrl.op : vpmc_pkg::OP_NOP;

    // case detection on the held count
    assign hold_c = is_remove ? (count_reg == '0)
                              : (count_reg >= vpmc_pkg::CNT_W'(vpmc_pkg::MAX_POINTS));
    assign last_c = is_remove && (count_reg == vpmc_pkg::CNT_W'(1));

    // jump condition select
    always_comb
    begin
        case (ctrl.cond)
            vpmc_pkg::C_NEVER:     jump = 1'b0;
            vpmc_pkg::C_HOLD:      jump = hold_c;
            vpmc_pkg::C_LAST:      jump = last_c;
            vpmc_pkg::C_DIV_BUSY:  jump = (div_cnt_reg != '0);
            vpmc_pkg::C_COV_MORE:  jump = (k_reg != vpmc_pkg::K_W'(vpmc_pkg::NCOV - 1));
            vpmc_pkg::C_MEAN_MORE: jump = (k_reg != vpmc_pkg::K_W'(vpmc_pkg::NAXIS - 1));
            vpmc_pkg::C_OUT_BUSY:  jump = out_valid_reg && out_stall;
            default:               jump = 1'b0;
        endcase
    end

    // next step, loop index and handshake flags
    always_comb
    begin
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        div_cnt_next   = div_cnt_reg;
        if (out_take)
            out_valid_next = 1'b0;
        if (div_cnt_reg != '0)
            div_cnt_next = div_cnt_reg - vpmc_pkg::DCNT_W'(1);
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = vpmc_pkg::A_CHK;
        end
        else if (busy_reg)
        begin
            pc_next = jump ? ctrl.target : pc_reg + vpmc_pkg::PC_W'(1);
        end
        case (op_eff)
            vpmc_pkg::OP_DIFF:
                k_next = '0;
            vpmc_pkg::OP_DIVGO:
                div_cnt_next = vpmc_pkg::DCNT_W'(vpmc_pkg::DIV_STEPS);
            vpmc_pkg::OP_COVSUM:
                k_next = (k_reg == vpmc_pkg::K_W'(vpmc_pkg::NCOV - 1))
                         ? '0 : k_reg + vpmc_pkg::K_W'(1);
            vpmc_pkg::OP_MEANSUM:
                k_next = (k_reg == vpmc_pkg::K_W'(vpmc_pkg::NAXIS - 1))
                         ? '0 : k_reg + vpmc_pkg::K_W'(1);
            vpmc_pkg::OP_COMMIT,
            vpmc_pkg::OP_CLEAR,
            vpmc_pkg::OP_HOLD:
            begin
                busy_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            default:
                k_next = k_reg;
        endcase
    end

    // divisor n+1 for insert, n-1 for remove
    assign den1_val = is_remove ? vpmc_pkg::D1_W'(count_reg) - vpmc_pkg::D1_W'(1)
                                : vpmc_pkg::D1_W'(count_reg) + vpmc_pkg::D1_W'(1);

    // operand pair of the current covariance term
    always_comb
    begin
        case (k_reg)
            3'd0:
            begin
                mul_a = d_reg[0];
                mul_b = d_reg[0];
            end
            3'd1:
            begin
                mul_a = d_reg[0];
                mul_b = d_reg[1];
            end
            3'd2:
            begin
                mul_a = d_reg[0];
                mul_b = d_reg[2];
            end
            3'd3:
            begin
                mul_a = d_reg[1];
                mul_b = d_reg[1];
            end
            3'd4:
            begin
                mul_a = d_reg[1];
                mul_b = d_reg[2];
            end
            3'd5:
            begin
                mul_a = d_reg[2];
                mul_b = d_reg[2];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // magnitude and count scaling ahead of the divider
    always_comb
    begin
        case (ctrl.src)
            vpmc_pkg::SRC_PROD: src_val = prod_reg;
            vpmc_pkg::SRC_COV:  src_val = vpmc_pkg::PRD_W'(cov_reg[k_reg]);
            vpmc_pkg::SRC_DIFF: src_val = vpmc_pkg::PRD_W'(d_reg[k_reg[1:0]]);
            default:            src_val = '0;
        endcase
        src_abs    = src_val[vpmc_pkg::PRD_W-1] ? vpmc_pkg::PRD_W'(-src_val)
                                                : vpmc_pkg::PRD_W'(src_val);
        scale_fac  = ctrl.scale_n ? count_reg : vpmc_pkg::CNT_W'(1);
        scale_prod = vpmc_pkg::MAG_W'(scale_fac) * vpmc_pkg::MAG_W'(src_abs);
        den_sel    = (ctrl.den == vpmc_pkg::DEN_SQ) ? den2_reg
                                                    : vpmc_pkg::D2_W'(den1_reg);
    end

    // one chunk of restoring division per cycle
    always_comb
    begin
        dv_rem   = div_rem_reg;
        dv_num   = div_num_reg;
        dv_trial = '0;
        for (int i = 0; i < vpmc_pkg::DIV_CHUNK; i++)
        begin
            dv_trial = {dv_rem, dv_num[vpmc_pkg::DIV_W-1]};
            dv_num   = {dv_num[vpmc_pkg::DIV_W-2:0], 1'b0};
            if (dv_trial >= {1'b0, div_den_reg})
            begin
                dv_rem    = vpmc_pkg::D2_W'(dv_trial - {1'b0, div_den_reg});
                dv_num[0] = 1'b1;
            end
            else
            begin
                dv_rem = dv_trial[vpmc_pkg::D2_W-1:0];
            end
        end
    end

    // signed quotient and the two combining sums
    always_comb
    begin
        quot_s = div_sgn_reg ? -$signed({1'b0, div_num_reg}) : $signed({1'b0, div_num_reg});
        if (is_remove)
        begin
            cov_sum  = vpmc_pkg::SUM_W'(quot_s) - vpmc_pkg::SUM_W'(b_reg);
            mean_sum = vpmc_pkg::SUM_W'(mean_reg[k_reg[1:0]]) - vpmc_pkg::SUM_W'(quot_s);
        end
        else
        begin
            cov_sum  = vpmc_pkg::SUM_W'(quot_s) + vpmc_pkg::SUM_W'(b_reg);
            mean_sum = vpmc_pkg::SUM_W'(mean_reg[k_reg[1:0]]) + vpmc_pkg::SUM_W'(quot_s);
        end
    end

    // control and statistics registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= vpmc_pkg::A_CHK;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= vpmc_pkg::ST_APPLIED;
            for (int i = 0; i < vpmc_pkg::NAXIS; i++)
                mean_reg[i] <= '0;
            for (int i = 0; i < vpmc_pkg::NCOV; i++)
                cov_reg[i] <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            k_reg         <= k_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            case (op_eff)
                vpmc_pkg::OP_COMMIT:
                begin
                    count_reg  <= is_remove ? count_reg - vpmc_pkg::CNT_W'(1)
                                            : count_reg + vpmc_pkg::CNT_W'(1);
                    status_reg <= vpmc_pkg::ST_APPLIED;
                    for (int i = 0; i < vpmc_pkg::NAXIS; i++)
                        mean_reg[i] <= mean_new_reg[i];
                    for (int i = 0; i < vpmc_pkg::NCOV; i++)
                        cov_reg[i] <= cov_new_reg[i];
                end
                vpmc_pkg::OP_CLEAR:
                begin
                    count_reg  <= '0;
                    status_reg <= vpmc_pkg::ST_CLEARED;
                    for (int i = 0; i < vpmc_pkg::NAXIS; i++)
                        mean_reg[i] <= '0;
                    for (int i = 0; i < vpmc_pkg::NCOV; i++)
                        cov_reg[i] <= '0;
                end
                vpmc_pkg::OP_HOLD:
                    status_reg <= is_remove ? vpmc_pkg::ST_EMPTY : vpmc_pkg::ST_FULL;
                default:
                    status_reg <= status_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            p_reg[0] <= px;
            p_reg[1] <= py;
            p_reg[2] <= pz;
        end
        if (div_cnt_reg != '0)
        begin
            div_num_reg <= dv_num;
            div_rem_reg <= dv_rem;
        end
        case (op_eff)
            vpmc_pkg::OP_DIFF:
            begin
                for (int i = 0; i < vpmc_pkg::NAXIS; i++)
                    d_reg[i] <= vpmc_pkg::DIF_W'(p_reg[i]) - vpmc_pkg::DIF_W'(mean_reg[i]);
                den1_reg <= den1_val;
                den2_reg <= vpmc_pkg::D2_W'(den1_val) * vpmc_pkg::D2_W'(den1_val);
            end
            vpmc_pkg::OP_MULD:
                prod_reg <= vpmc_pkg::PRD_W'(mul_a) * vpmc_pkg::PRD_W'(mul_b);
            vpmc_pkg::OP_SCALE:
            begin
                mag_reg <= scale_prod;
                sgn_reg <= src_val[vpmc_pkg::PRD_W-1];
            end
            vpmc_pkg::OP_DIVGO:
            begin
                div_num_reg <= vpmc_pkg::DIV_W'(mag_reg) + vpmc_pkg::DIV_W'(den_sel >> 1);
                div_rem_reg <= '0;
                div_den_reg <= den_sel;
                div_sgn_reg <= sgn_reg;
            end
            vpmc_pkg::OP_KEEPB:
                b_reg <= quot_s;
            vpmc_pkg::OP_COVSUM:
                cov_new_reg[k_reg] <= vpmc_pkg::sat_cov(cov_sum);
            vpmc_pkg::OP_MEANSUM:
                mean_new_reg[k_reg[1:0]] <= vpmc_pkg::sat_mean(mean_sum);
            default:
                sgn_reg <= sgn_reg;
        endcase
    end

    // result ports straight from the held statistics
    assign count_ext   = {5'b0, count_reg};
    assign out_valid   = out_valid_reg;
    assign point_count = count_ext[4:0];
    assign mean_x      = mean_reg[0];
    assign mean_y      = mean_reg[1];
    assign mean_z      = mean_reg[2];
    assign cov_xx      = cov_reg[0];
    assign cov_xy      = cov_reg[1];
    assign cov_xz      = cov_reg[2];
    assign cov_yy      = cov_reg[3];
    assign cov_yz      = cov_reg[4];
    assign cov_zz      = cov_reg[5];
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    // a commit always presents a result on the next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (op_eff == vpmc_pkg::OP_COMMIT) |=> out_valid)
        else $error("commit without result");

    // the count never passes the cap
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= vpmc_pkg::CNT_W'(vpmc_pkg::MAX_POINTS))
        else $error("point count above cap");

    // divider is idle whenever no request is being worked on
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (div_cnt_reg == '0))
        else $error("divider running while idle");

    // a cleared result reports an empty voxel
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == vpmc_pkg::ST_CLEARED)) |-> (point_count == '0))
        else $error("cleared result with points held");
`endif

endmodule
`default_nettype wire
